/* hdl/fgfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fgfr_pkg: shared types, codes and glyph ROM of the glyph frame renderer
// Command and job codes, register index, the job record passed from the
// front end to the draw engine, and the 5x7 font with its code lookup.
// ----------------------------------------------------------------------------
package fgfr_pkg;

  // Signed pixel x of a job; covers the line origin plus the widest cell offset
  localparam int X_W = 12;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_CELL    = 2'd1;
  localparam logic [1:0] CMD_MARQUEE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SKIP  = 2'd3;

  localparam logic [0:0] REG_MARQUEE_PERIOD = 1'b0;
  localparam logic [9:0] MARQUEE_PERIOD_RESET = 10'd420;

  localparam int GLYPH_COUNT = 39;

  // Column 0 in the top byte; bit r of a column is row r below the top
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h0036360000, 40'h3E5149493E, 40'h00427F4000,
    40'h6251494946, 40'h2249494936, 40'h1814127F10, 40'h2745454539,
    40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
    40'h7F0808087F, 40'h3854545418, 40'h00007F4040, 40'h1C2222221C,
    40'h3E4141413E, 40'h7F40404040, 40'h7F49494941, 40'h1F2040201F,
    40'h6314081463, 40'h7C08040408, 40'h384444487F, 40'h01017F0101,
    40'h464949291E, 40'h00417F4100, 40'h7F0408107F, 40'h3E4149497A,
    40'h2054545478, 40'h7F0204027F, 40'h7F08141408, 40'h3F4040403F,
    40'h7F49494936, 40'h7F08142241, 40'h3E41414122, 40'h7F09090901,
    40'h0304780403, 40'h22147F1422, 40'h0808080808
  };

  typedef struct packed {
    logic [1:0]            op;
    logic [5:0]            glyph;
    logic signed [X_W-1:0] x0;
    logic signed [X_W-1:0] x1;
    logic                  two_pass;
    logic [5:0]            y_top;
    logic [9:0]            addr;
  } job_t;

  // Unknown codes map to the blank glyph at index zero
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [5:0] idx;
    unique case (code)
      8'h20:   idx = 6'd0;
      8'h3A:   idx = 6'd1;
      8'h30:   idx = 6'd2;
      8'h31:   idx = 6'd3;
      8'h32:   idx = 6'd4;
      8'h33:   idx = 6'd5;
      8'h34:   idx = 6'd6;
      8'h35:   idx = 6'd7;
      8'h36:   idx = 6'd8;
      8'h37:   idx = 6'd9;
      8'h38:   idx = 6'd10;
      8'h39:   idx = 6'd11;
      8'h48:   idx = 6'd12;
      8'h65:   idx = 6'd13;
      8'h6C:   idx = 6'd14;
      8'h6F:   idx = 6'd15;
      8'h4F:   idx = 6'd16;
      8'h4C:   idx = 6'd17;
      8'h45:   idx = 6'd18;
      8'h56:   idx = 6'd19;
      8'h57:   idx = 6'd20;
      8'h72:   idx = 6'd21;
      8'h64:   idx = 6'd22;
      8'h54:   idx = 6'd23;
      8'h53:   idx = 6'd24;
      8'h49:   idx = 6'd25;
      8'h4E:   idx = 6'd26;
      8'h47:   idx = 6'd27;
      8'h41:   idx = 6'd28;
      8'h4D:   idx = 6'd29;
      8'h50:   idx = 6'd30;
      8'h55:   idx = 6'd31;
      8'h42:   idx = 6'd32;
      8'h4B:   idx = 6'd33;
      8'h43:   idx = 6'd34;
      8'h46:   idx = 6'd35;
      8'h59:   idx = 6'd36;
      8'h2A:   idx = 6'd37;
      8'h2D:   idx = 6'd38;
      default: idx = 6'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [6:0] glyph_column(input logic [5:0] idx, input logic [2:0] col);
    logic [39:0] g;
    g = (int'(idx) < GLYPH_COUNT) ? GLYPH_ROM[idx] : 40'h0;
    if (col > 3'd4) begin
      return 7'h00;
    end
    return g[8*(4-int'(col)) +: 7];
  endfunction

endpackage
`default_nettype wire

/* hdl/fgfr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fgfr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fgfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/fgfr_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fgfr_fifo: job queue between front end and draw engine
// Small register FIFO of decoded jobs; head is valid whenever not empty.
// ----------------------------------------------------------------------------
module fgfr_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  fgfr_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output fgfr_pkg::job_t     head,
  output logic               empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fgfr_pkg::job_t entries [DEPTH];
  logic [IW-1:0]  wr_ptr;
  logic [IW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/fgfr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fgfr_front: command intake and classification
// Takes one command, looks up its glyph, works out pixel x positions (with a
// bit-serial scroll remainder for marquee draws) and queues the job.
// ----------------------------------------------------------------------------
module fgfr_front #(
  parameter int CELL_WIDTH = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 init_busy,
  input  wire logic [9:0]           marquee_period,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           command,
  input  wire logic [7:0]           char_code,
  input  wire logic signed [10:0]   x_origin,
  input  wire logic [5:0]           cell_index,
  input  wire logic [5:0]           y_top,
  input  wire logic [9:0]           scroll_amount,
  input  wire logic [9:0]           read_address,
  output logic                      push,
  output fgfr_pkg::job_t            push_job,
  input  wire logic                 full
);

  localparam int XW = fgfr_pkg::X_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [3:0] MOD_LAST = 4'd9;

  logic [1:0]  state;
  logic [1:0]  cmd;
  logic [7:0]  code;
  logic [10:0] xo;
  logic [5:0]  cell_idx;
  logic [5:0]  ytop;
  logic [9:0]  sc;
  logic [9:0]  addr;
  logic [9:0]  rem;
  logic [3:0]  cnt;

  logic          accept;
  logic [10:0]   trial;
  logic          trial_ge;
  logic [9:0]    rem_next;
  logic [XW-1:0] cell_off;
  logic [XW-1:0] x_cell;
  logic [XW-1:0] x_mq;
  logic [XW-1:0] x_mq1;

  assign in_stall = (state != F_IDLE) || init_busy;
  assign accept   = in_valid && !in_stall;
  assign push     = (state == F_PUSH) && !full;

  // One remainder bit per cycle, MSB of the scroll first
  assign trial    = {rem, sc[9]};
  assign trial_ge = (trial >= {1'b0, marquee_period});
  assign rem_next = trial_ge ? 10'(trial - {1'b0, marquee_period}) : trial[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= (command == fgfr_pkg::CMD_MARQUEE && marquee_period != '0)
                     ? F_MOD : F_PUSH;
          end
        end
        F_MOD: begin
          if (cnt == MOD_LAST) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= command;
      code     <= char_code;
      xo       <= x_origin;
      cell_idx <= cell_index;
      ytop     <= y_top;
      sc       <= scroll_amount;
      addr     <= read_address;
      rem      <= '0;
      cnt      <= '0;
    end else if (state == F_MOD) begin
      rem <= rem_next;
      sc  <= {sc[8:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  assign cell_off = XW'(int'(cell_idx) * CELL_WIDTH);
  assign x_cell   = {{(XW-11){xo[10]}}, xo} + cell_off;
  assign x_mq     = cell_off - {{(XW-10){1'b0}}, rem};
  assign x_mq1    = x_mq + {{(XW-10){1'b0}}, marquee_period};

  always_comb begin
    push_job.glyph    = fgfr_pkg::glyph_index(code);
    push_job.y_top    = ytop;
    push_job.addr     = addr;
    push_job.x0       = x_cell;
    push_job.x1       = x_mq1;
    push_job.two_pass = 1'b0;
    case (cmd)
      fgfr_pkg::CMD_CLEAR: push_job.op = fgfr_pkg::OP_CLEAR;
      fgfr_pkg::CMD_CELL:  push_job.op = fgfr_pkg::OP_DRAW;
      fgfr_pkg::CMD_MARQUEE: begin
        push_job.op       = (marquee_period == '0) ? fgfr_pkg::OP_SKIP : fgfr_pkg::OP_DRAW;
        push_job.x0       = x_mq;
        push_job.two_pass = 1'b1;
      end
      default: push_job.op = fgfr_pkg::OP_READ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fgfr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fgfr_back: frame store draw engine
// Owns the frame store. Runs clear sweeps, per-byte read-modify-write of glyph
// columns with clipping, and byte reads; holds the result register.
// ----------------------------------------------------------------------------
module fgfr_back #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  fgfr_pkg::job_t     head,
  input  wire logic          empty,
  output logic               pop,
  output logic               init_busy,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         read_data
);

  localparam int XW          = fgfr_pkg::X_W;
  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int XB          = $clog2(SCREEN_WIDTH);
  localparam logic [7:0] LAST_MASK =
    (SCREEN_HEIGHT % 8 == 0) ? 8'hFF : 8'((1 << (SCREEN_HEIGHT % 8)) - 1);

  localparam logic [2:0] B_INIT  = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_CLEAR = 3'd2;
  localparam logic [2:0] B_SLOT  = 3'd3;
  localparam logic [2:0] B_WRITE = 3'd4;
  localparam logic [2:0] B_READ  = 3'd5;
  localparam logic [2:0] B_DONE  = 3'd6;

  localparam logic [3:0] SLOT_LAST = 4'd9;

  logic [2:0]     state;
  logic [AW-1:0]  sweep;
  fgfr_pkg::job_t cur;
  logic           pass;
  logic [3:0]     slot;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_mask;
  logic [7:0]     res;

  logic [2:0]     col;
  logic           half;
  logic [XW-1:0]  xs;
  logic [6:0]     colbits;
  logic [15:0]    shifted;
  logic [7:0]     byte_sel;
  logic [3:0]     page;
  logic           x_ok;
  logic           page_ok;
  logic [7:0]     pmask;
  logic [7:0]     slot_mask;
  logic [AW-1:0]  slot_addr;
  logic           in_range;
  logic           load_out;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic [AW-1:0]  raddr;
  logic [7:0]     rdata;

  // Slot = column pair of bytes: even slot is the glyph top page, odd the next
  assign col      = slot[3:1];
  assign half     = slot[0];
  assign xs       = (pass ? cur.x1 : cur.x0) + {{(XW-3){1'b0}}, col};
  assign colbits  = fgfr_pkg::glyph_column(cur.glyph, col);
  assign shifted  = {9'b0, colbits} << cur.y_top[2:0];
  assign byte_sel = half ? shifted[15:8] : shifted[7:0];
  assign page     = {1'b0, cur.y_top[5:3]} + {3'b0, half};
  assign x_ok     = !xs[XW-1] && (xs < XW'(SCREEN_WIDTH));
  assign page_ok  = (int'(page) < PAGES);
  // Drop rows below the screen on a partly used last page
  assign pmask     = (int'(page) == PAGES - 1) ? LAST_MASK : 8'hFF;
  assign slot_mask = (x_ok && page_ok) ? (byte_sel & pmask) : 8'h00;
  assign slot_addr = AW'(int'(xs[XB-1:0]) + int'(page) * SCREEN_WIDTH);
  assign in_range  = (int'(cur.addr) < STORE_BYTES);

  assign pop       = (state == B_IDLE) && !empty;
  assign init_busy = (state == B_INIT);
  assign load_out  = (state == B_DONE) && (!out_valid || !out_stall);

  assign we    = (state == B_INIT) || (state == B_CLEAR) || (state == B_WRITE);
  assign waddr = (state == B_WRITE) ? wr_addr : sweep;
  assign wdata = (state == B_WRITE) ? (rdata | wr_mask) : 8'h00;
  assign raddr = (state == B_IDLE) ? AW'(head.addr) : slot_addr;

  fgfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      pass      <= 1'b0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        read_data <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        B_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(STORE_BYTES - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cur  <= head;
            pass <= 1'b0;
            slot <= '0;
            res  <= 8'h00;
            unique case (head.op)
              fgfr_pkg::OP_CLEAR: begin
                sweep <= '0;
                state <= B_CLEAR;
              end
              fgfr_pkg::OP_DRAW: state <= B_SLOT;
              fgfr_pkg::OP_READ: state <= B_READ;
              default:           state <= B_DONE;
            endcase
          end
        end
        B_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(STORE_BYTES - 1)) begin
            state <= B_DONE;
          end
        end
        B_SLOT, B_WRITE: begin
          if (state == B_SLOT && slot_mask != 8'h00) begin
            // Issue the read now, merge and write back next cycle
            wr_addr <= slot_addr;
            wr_mask <= slot_mask;
            state   <= B_WRITE;
          end else if (slot == SLOT_LAST) begin
            if (cur.two_pass && !pass) begin
              pass  <= 1'b1;
              slot  <= '0;
              state <= B_SLOT;
            end else begin
              state <= B_DONE;
            end
          end else begin
            slot  <= slot + 1'b1;
            state <= B_SLOT;
          end
        end
        B_READ: begin
          res   <= in_range ? rdata : 8'h00;
          state <= B_DONE;
        end
        B_DONE: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_write_after_slot: assert property (@(posedge clk) disable iff (rst)
    (state == B_WRITE) |-> ($past(state) == B_SLOT))
    else $error("store write not preceded by its read");

  a_write_mask: assert property (@(posedge clk) disable iff (rst)
    (state == B_WRITE) |-> (wr_mask != 8'h00))
    else $error("read-modify-write with empty mask");

  a_init_no_jobs: assert property (@(posedge clk) disable iff (rst)
    (state == B_INIT) |-> empty)
    else $error("job queued during power-up clear");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (state == B_IDLE)))
    else $error("finished job did not reach output register");

endmodule
`default_nettype wire

/* hdl/font_glyph_frame_renderer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// font_glyph_frame_renderer_top: 5x7 character generator into a page frame
// Draws glyphs from a fixed font into a page-organized monochrome store,
// clears it, or reads back one byte. Marquee period is set over APB.
// ----------------------------------------------------------------------------
// Every command returns one read_data item (zero except for byte reads).
// The front end holds in_stall until each command is queued; for a marquee
// draw with a nonzero period it first finds the scroll remainder one bit per cycle.
// Up to four decoded commands queue ahead of the draw engine, which sets the
// sustained rate: a cell draw steps through ten byte slots of one glyph, passing
// over a slot that is empty or off screen and doing a read-modify-write of the
// store for the others, a marquee draw does this for two positions, and a clear
// sweeps the store one byte a cycle. After reset the engine clears the store,
// all SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (1024 by default), with in_stall
// high; APB writes are taken meanwhile.
// ----------------------------------------------------------------------------
module font_glyph_frame_renderer_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int CELL_WIDTH    = 7
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          command,
  input  wire logic [7:0]          char_code,
  input  wire logic signed [10:0]  x_origin,
  input  wire logic [5:0]          cell_index,
  input  wire logic [5:0]          y_top,
  input  wire logic [9:0]          scroll_amount,
  input  wire logic [9:0]          read_address,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               read_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int QUEUE_DEPTH = 4;

  logic [9:0]     marquee_period;
  logic           init_busy;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  fgfr_pkg::job_t push_job;
  fgfr_pkg::job_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == fgfr_pkg::REG_MARQUEE_PERIOD) ? {22'b0, marquee_period}
                                                                : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marquee_period <= fgfr_pkg::MARQUEE_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2:2] == fgfr_pkg::REG_MARQUEE_PERIOD) begin
      marquee_period <= pwdata[9:0];
    end
  end

  fgfr_front #(
    .CELL_WIDTH (CELL_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .init_busy      (init_busy),
    .marquee_period (marquee_period),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .char_code      (char_code),
    .x_origin       (x_origin),
    .cell_index     (cell_index),
    .y_top          (y_top),
    .scroll_amount  (scroll_amount),
    .read_address   (read_address),
    .push           (push),
    .push_job       (push_job),
    .full           (full)
  );

  fgfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  fgfr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
  );

endmodule
`default_nettype wire

/* sim/font_glyph_frame_renderer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_frame_renderer_top_tb: self-checking bench for the glyph renderer
// Drives clear, cell draw, marquee draw and byte read commands with random
// gaps and output stalls. A shadow copy of the frame store predicts every
// read_data result, and the marquee period is rewritten between phases.
// ----------------------------------------------------------------------------
module font_glyph_frame_renderer_top_tb;

  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 64;
  localparam int CELL_W      = 7;
  localparam int STORE_BYTES = SCREEN_W * ((SCREEN_H + 7) / 8);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] PERIOD_ADDR = 3'({fgfr_pkg::REG_MARQUEE_PERIOD, 2'b00});
  // Codes present in the font, in ROM order
  localparam logic [8*39-1:0] FONT_CHARS = " :0123456789HeloOLEVWrdTSINGAMPUBKCFY*-";

  typedef struct {
    logic [1:0]         command;
    logic [7:0]         code;
    logic signed [10:0] x_origin;
    logic [5:0]         cell_idx;
    logic [5:0]         y;
    logic [9:0]         scroll;
    logic [9:0]         addr;
  } render_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = fgfr_pkg::CMD_READ;
  logic [7:0]         char_code = '0;
  logic signed [10:0] x_origin = '0;
  logic [5:0]         cell_index = '0;
  logic [5:0]         y_top = '0;
  logic [9:0]         scroll_amount = '0;
  logic [9:0]         read_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         read_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [7:0] shadow_frame [STORE_BYTES];
  logic [9:0] marquee_len;
  logic [7:0] pending_read_data [$];
  logic [7:0] want_data;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;
  int         last_x = 0;
  int         last_y = 0;

  font_glyph_frame_renderer_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .CELL_WIDTH   (CELL_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .char_code    (char_code),
    .x_origin     (x_origin),
    .cell_index   (cell_index),
    .y_top        (y_top),
    .scroll_amount(scroll_amount),
    .read_address (read_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Column 0 in the top byte, bit r of a column is row r below the top
  function automatic logic [39:0] font_pattern(input logic [7:0] code);
    case (code)
      ":":     return 40'h0036360000;
      "0":     return 40'h3E5149493E;
      "1":     return 40'h00427F4000;
      "2":     return 40'h6251494946;
      "3":     return 40'h2249494936;
      "4":     return 40'h1814127F10;
      "5":     return 40'h2745454539;
      "6":     return 40'h3C4A494930;
      "7":     return 40'h0171090503;
      "8":     return 40'h3649494936;
      "9":     return 40'h064949291E;
      "H":     return 40'h7F0808087F;
      "e":     return 40'h3854545418;
      "l":     return 40'h00007F4040;
      "o":     return 40'h1C2222221C;
      "O":     return 40'h3E4141413E;
      "L":     return 40'h7F40404040;
      "E":     return 40'h7F49494941;
      "V":     return 40'h1F2040201F;
      "W":     return 40'h6314081463;
      "r":     return 40'h7C08040408;
      "d":     return 40'h384444487F;
      "T":     return 40'h01017F0101;
      "S":     return 40'h464949291E;
      "I":     return 40'h00417F4100;
      "N":     return 40'h7F0408107F;
      "G":     return 40'h3E4149497A;
      "A":     return 40'h2054545478;
      "M":     return 40'h7F0204027F;
      "P":     return 40'h7F08141408;
      "U":     return 40'h3F4040403F;
      "B":     return 40'h7F49494936;
      "K":     return 40'h7F08142241;
      "C":     return 40'h3E41414122;
      "F":     return 40'h7F09090901;
      "Y":     return 40'h0304780403;
      "*":     return 40'h22147F1422;
      "-":     return 40'h0808080808;
      default: return 40'h0;
    endcase
  endfunction

  function automatic void draw_glyph(input int x, input int y, input logic [7:0] code);
    logic [39:0] pat;
    logic [6:0]  bits;
    int          px;
    int          py;
    pat = font_pattern(code);
    for (int col = 0; col < 5; col++) begin
      bits = pat[8*(4-col) +: 7];
      for (int row = 0; row < 7; row++) begin
        px = x + col;
        py = y + row;
        // drop pixels outside the screen
        if (bits[row] && px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
          shadow_frame[px + (py >> 3) * SCREEN_W][py & 7] = 1'b1;
        end
      end
    end
  endfunction

  function automatic logic [7:0] predict_read_data(input render_cmd_t c);
    int off;
    int x0;
    logic [7:0] data;
    data = 8'h00;
    case (c.command)
      fgfr_pkg::CMD_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      fgfr_pkg::CMD_CELL: begin
        draw_glyph(int'(c.x_origin) + int'(c.cell_idx) * CELL_W, int'(c.y), c.code);
      end
      fgfr_pkg::CMD_MARQUEE: begin
        if (marquee_len != 10'd0) begin
          off = int'(c.scroll) % int'(marquee_len);
          x0  = int'(c.cell_idx) * CELL_W - off;
          draw_glyph(x0, int'(c.y), c.code);
          draw_glyph(x0 + int'(marquee_len), int'(c.y), c.code);
        end
      end
      default: begin
        if (int'(c.addr) < STORE_BYTES) data = shadow_frame[c.addr];
      end
    endcase
    return data;
  endfunction

  function automatic render_cmd_t make_cmd(input logic [1:0] cmd, input logic [7:0] code,
                                           input int xo, input int cell_idx, input int y,
                                           input int scroll, input int addr);
    render_cmd_t c;
    c.command  = cmd;
    c.code     = code;
    c.x_origin = 11'(xo);
    c.cell_idx = 6'(cell_idx);
    c.y        = 6'(y);
    c.scroll   = 10'(scroll);
    c.addr     = 10'(addr);
    return c;
  endfunction

  function automatic logic [7:0] random_font_char();
    int k;
    k = $urandom_range(0, 38);
    return FONT_CHARS[8*(38-k) +: 8];
  endfunction

  // Mostly draws near the screen followed by reads aimed at what was drawn
  function automatic render_cmd_t random_command();
    render_cmd_t c;
    int pick;
    int xi;
    int tx;
    int page;
    c.command  = 2'($urandom);
    c.code     = 8'($urandom);
    c.x_origin = 11'($urandom);
    c.cell_idx = 6'($urandom);
    c.y        = 6'($urandom);
    c.scroll   = 10'($urandom);
    c.addr     = 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      c.command = fgfr_pkg::CMD_CLEAR;
    end else if (pick < 37) begin
      c.command = fgfr_pkg::CMD_CELL;
      if ($urandom_range(0, 3) != 0) c.code = random_font_char();
      if ($urandom_range(0, 4) != 0) begin
        xi = int'($urandom_range(0, 160)) - 20;
        c.x_origin = 11'(xi);
        c.cell_idx = 6'($urandom_range(0, 15));
      end
      last_x = int'(c.x_origin) + int'(c.cell_idx) * CELL_W;
      last_y = int'(c.y);
    end else if (pick < 57) begin
      c.command = fgfr_pkg::CMD_MARQUEE;
      if ($urandom_range(0, 3) != 0) c.code = random_font_char();
      if (marquee_len != 10'd0) begin
        last_x = int'(c.cell_idx) * CELL_W - int'(c.scroll) % int'(marquee_len);
        if ($urandom_range(0, 1) != 0) last_x = last_x + int'(marquee_len);
      end
      last_y = int'(c.y);
    end else begin
      c.command = fgfr_pkg::CMD_READ;
      if ($urandom_range(0, 2) != 0) begin
        tx = last_x + int'($urandom_range(0, 5));
        if (tx < 0 || tx >= SCREEN_W) tx = $urandom_range(0, SCREEN_W - 1);
        page = (last_y >> 3) + int'($urandom_range(0, 1));
        if (page > 7) page = 7;
        c.addr = 10'(tx + page * SCREEN_W);
      end
    end
    return c;
  endfunction

  // Present one command, hold it until taken, and record its expected byte
  task automatic send_command(input render_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= c.command;
    char_code     <= c.code;
    x_origin      <= c.x_origin;
    cell_index    <= c.cell_idx;
    y_top         <= c.y;
    scroll_amount <= c.scroll;
    read_address  <= c.addr;
    do @(posedge clk); while (in_stall);
    pending_read_data.push_back(predict_read_data(c));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_read_data.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the period while idle, then read it back
  task automatic set_marquee_period(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERIOD_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    marquee_len = value[9:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[9:0] !== value[9:0]) begin
      $error("marquee_period: expected %0d, actual %0d", value[9:0], prdata[9:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_readback();
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'hFF, -1, 63, 63, 1023, STORE_BYTES - 1));
  endtask

  task automatic test_cell_draws();
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "0", 0, 0, 0, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 2));
    // right and bottom clipping at the last byte of the store
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "8", 120, 1, 60, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 127 + 7 * SCREEN_W));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 126 + 7 * SCREEN_W));
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "*", -1024, 63, 0, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "W", 1023, 0, 0, 0, 0));
    // left clipping with a glyph spanning two pages
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "H", -3, 0, 5, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 1));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 1 + SCREEN_W));
    send_command(make_cmd(fgfr_pkg::CMD_CELL, 8'hFF, 20, 0, 0, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 20));
    send_command(make_cmd(fgfr_pkg::CMD_CELL, "e", -1, 9, 63, 0, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 62 + 7 * SCREEN_W));
  endtask

  task automatic test_marquee_draws();
    set_marquee_period(32'd0);
    send_command(make_cmd(fgfr_pkg::CMD_MARQUEE, "I", 0, 2, 0, 5, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 15));
    set_marquee_period(32'hFFFF_FFFF);
    send_command(make_cmd(fgfr_pkg::CMD_MARQUEE, "1", 0, 0, 8, 1023, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 2 + SCREEN_W));
    set_marquee_period(32'd1);
    send_command(make_cmd(fgfr_pkg::CMD_MARQUEE, "-", 0, 5, 16, 1023, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 37 + 2 * SCREEN_W));
    set_marquee_period(32'd420);
    send_command(make_cmd(fgfr_pkg::CMD_MARQUEE, "Y", 0, 63, 0, 400, 0));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 43));
  endtask

  task automatic test_clear();
    send_command(make_cmd(fgfr_pkg::CMD_CLEAR, "8", 5, 5, 5, 5, 43));
    send_command(make_cmd(fgfr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 43));
  endtask

  task automatic test_random_traffic();
    logic [31:0] periods [5];
    periods[0] = 32'd420;
    periods[1] = {$urandom} | 32'h3FF;
    periods[2] = 32'd0;
    periods[3] = 32'd1;
    periods[4] = ($urandom & 32'hFFFF_FC00) | 32'($urandom_range(2, 1022));
    for (int phase = 0; phase < 5; phase++) begin
      set_marquee_period(periods[phase]);
      for (int i = 0; i < 250; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_command(random_command());
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: draw a fresh stall length after every result
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
      if (pending_read_data.size() == 0) begin
        $error("read_data: no command pending, actual %0h", read_data);
        fail_count++;
      end else begin
        want_data = pending_read_data.pop_front();
        if (read_data !== want_data) begin
          $error("read_data: expected %0h, actual %0h", want_data, read_data);
          fail_count++;
        end
      end
    end
  end

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    marquee_len = fgfr_pkg::MARQUEE_PERIOD_RESET;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_reset_readback();
    test_cell_draws();
    test_marquee_draws();
    test_clear();
    test_random_traffic();
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_read_data.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
